// ----- sv/aodg_pkg.sv -----
package aodg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_VOL,
    ST_DONE
  } aodg_state_t;

  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 16;
  localparam int CoefWidth = 16;
  localparam int LenWidth = 10;

  localparam logic [CfgIdxWidth-1:0] CFG_OUTPUT_GAIN   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DELAY_LENGTH  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_INVERT_PHASE  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_MUTE_OUTPUT   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_VOLUME        = 3'd4;

  localparam logic [CoefWidth-1:0] GAIN_RESET   = 16'd4096;
  localparam logic [CoefWidth-1:0] VOLUME_RESET = 16'd32768;

  typedef struct packed {
    logic                len_we;
    logic [LenWidth-1:0] len_value;
    logic                step;
  } aodg_dly_ctrl_t;

endpackage

// ----- sv/aodg_mac.sv -----
module aodg_mac
  import aodg_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           frac15,
  input  logic signed [SAMPLE_WIDTH-1:0] a,
  input  logic        [CoefWidth-1:0]    b,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int PW = SAMPLE_WIDTH + CoefWidth + 1;
  localparam logic signed [PW:0] SMAX = (PW+1)'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [PW:0] SMIN = -SMAX - (PW+1)'(1);

  logic signed [PW-1:0] prod;
  logic                 frac15_q;
  logic signed [PW:0]   rsum;
  logic signed [PW:0]   shifted;

  always_ff @(posedge clk) begin
    if (load) begin
      prod     <= PW'($signed(a) * $signed({1'b0, b}));
      frac15_q <= frac15;
    end
  end

  always_comb begin
    rsum    = {prod[PW-1], prod} + (frac15_q ? (PW+1)'(1 << 14) : (PW+1)'(1 << 11));
    shifted = frac15_q ? (rsum >>> 15) : (rsum >>> 12);
    if (shifted > SMAX) begin
      result = SMAX[SAMPLE_WIDTH-1:0];
    end else if (shifted < SMIN) begin
      result = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      result = shifted[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ----- sv/aodg_delay.sv -----
module aodg_delay
  import aodg_pkg::*;
#(
  parameter int DELAY_DEPTH  = 1024,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  aodg_dly_ctrl_t          ctrl,
  input  logic [SAMPLE_WIDTH-1:0] wdata,
  output logic [SAMPLE_WIDTH-1:0] rdata,
  output logic                    busy
);

  localparam int PW = $clog2(DELAY_DEPTH);

  logic [SAMPLE_WIDTH-1:0] mem [DELAY_DEPTH];
  logic [PW-1:0]           wp;
  logic [PW:0]             fill;
  logic [LenWidth-1:0]     off;
  logic [SAMPLE_WIDTH-1:0] mem_q;
  logic [SAMPLE_WIDTH-1:0] wdata_q;
  logic                    byp_q;
  logic                    vld_q;

  logic [PW:0]   wp_e;
  logic [PW:0]   off_e;
  logic [PW:0]   rd_w;
  logic [PW-1:0] rd;
  logic          off_big;

  always_comb begin
    wp_e    = {1'b0, wp};
    off_e   = (PW+1)'(off);
    rd_w    = (wp_e >= off_e) ? wp_e - off_e : wp_e + (PW+1)'(DELAY_DEPTH) - off_e;
    rd      = rd_w[PW-1:0];
    off_big = 17'(off) >= 17'(DELAY_DEPTH);
  end

  // offset reduced modulo depth after each write of the length
  always_ff @(posedge clk) begin
    if (rst) begin
      off  <= '0;
      busy <= 1'b0;
    end else if (ctrl.len_we) begin
      off  <= ctrl.len_value;
      busy <= 1'b1;
    end else if (busy) begin
      if (off_big) begin
        off <= off - LenWidth'(DELAY_DEPTH);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.step) begin
      wp <= (wp_e == (PW+1)'(DELAY_DEPTH - 1)) ? '0 : wp + PW'(1);
      if (fill != (PW+1)'(DELAY_DEPTH)) begin
        fill <= fill + (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      mem[wp] <= wdata;
      mem_q   <= mem[rd];
      wdata_q <= wdata;
      byp_q   <= (off == '0);
      vld_q   <= ({1'b0, rd} < fill);
    end
  end

  assign rdata = byp_q ? wdata_q : (vld_q ? mem_q : '0);

endmodule

// ----- sv/audio_output_delay_gain_stage.sv -----
// channel   direction  beat contents
// s_axis    in         tdata: sample_in
// m_axis    out        tdata: sample_out
// cfg       in         cfg_index selects register, cfg_data is the value
//
// Each sample takes four steps in order: gain multiply, delay store write/read,
// volume multiply, output load; one multiplier serves both gains.
// After a delay_length write, s_axis waits on the delay's busy flag, set by the
// write and held through each subtraction of DELAY_DEPTH in the modulo reduction.
// Synchronous active-high reset; the delay store reads as zero until written.
// A sample is accepted while an earlier result waits on m_axis.
module audio_output_delay_gain_stage
  import aodg_pkg::*;
#(
  parameter int DELAY_DEPTH  = 1024,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample_in
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample_out
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CfgIdxWidth-1:0]                    cfg_index,
  input  logic [CfgDataWidth-1:0]                   cfg_data
);

  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  aodg_state_t state, state_next;

  logic [CoefWidth-1:0] output_gain;
  logic [LenWidth-1:0]  delay_length;
  logic                 invert_phase;
  logic                 mute_output;
  logic [CoefWidth-1:0] volume;

  logic signed [SAMPLE_WIDTH-1:0] samp;
  logic        [SAMPLE_WIDTH-1:0] out_q;

  logic                           s_accept;
  logic                           cfg_accept;
  logic                           out_free;
  logic                           delay_on;
  logic                           mac_load;
  logic                           mac_frac15;
  logic signed [SAMPLE_WIDTH-1:0] mac_a;
  logic        [CoefWidth-1:0]    mac_b;
  logic signed [SAMPLE_WIDTH-1:0] mac_res;
  logic signed [SAMPLE_WIDTH-1:0] pre;
  logic signed [SAMPLE_WIDTH-1:0] vol_in;
  logic        [SAMPLE_WIDTH-1:0] dly_rdata;
  logic                           dly_busy;
  logic                           out_load;
  aodg_dly_ctrl_t                 dly_ctrl;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign delay_on   = (delay_length != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_gain  <= GAIN_RESET;
      delay_length <= '0;
      invert_phase <= 1'b0;
      mute_output  <= 1'b0;
      volume       <= VOLUME_RESET;
    end else if (cfg_accept) begin
      case (cfg_index)
        CFG_OUTPUT_GAIN:  output_gain  <= cfg_data;
        CFG_DELAY_LENGTH: delay_length <= cfg_data[LenWidth-1:0];
        CFG_INVERT_PHASE: invert_phase <= cfg_data[0];
        CFG_MUTE_OUTPUT:  mute_output  <= cfg_data[0];
        CFG_VOLUME:       volume       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_accept) state_next = ST_STORE;
      ST_STORE: state_next = ST_VOL;
      ST_VOL:   state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready      = 1'b0;
    mac_load           = 1'b0;
    mac_frac15         = 1'b0;
    out_load           = 1'b0;
    dly_ctrl.step      = 1'b0;
    dly_ctrl.len_we    = cfg_accept && (cfg_index == CFG_DELAY_LENGTH);
    dly_ctrl.len_value = cfg_data[LenWidth-1:0];
    case (state)
      ST_IDLE: begin
        s_axis_tready = !dly_busy;
        mac_load      = s_accept;
      end
      ST_STORE: dly_ctrl.step = delay_on;
      ST_VOL: begin
        mac_load   = 1'b1;
        mac_frac15 = 1'b1;
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    pre = delay_on ? $signed(dly_rdata) : samp;
    if (invert_phase) begin
      pre = (pre == SMIN) ? SMAX : -pre;
    end
    vol_in = mute_output ? '0 : pre;
  end

  assign mac_a = (state == ST_VOL) ? vol_in : $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
  assign mac_b = (state == ST_VOL) ? volume : output_gain;

  aodg_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mac (
    .clk   (clk),
    .load  (mac_load),
    .frac15(mac_frac15),
    .a     (mac_a),
    .b     (mac_b),
    .result(mac_res)
  );

  aodg_delay #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_delay (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dly_ctrl),
    .wdata(mac_res),
    .rdata(dly_rdata),
    .busy (dly_busy)
  );

  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      samp <= mac_res;
    end
    if (out_load) begin
      out_q <= mac_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = DW'(out_q);

endmodule
